### sv/assert_macros.svh
// assertion helpers, clocked on i_clk and held off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/ksmh_pkg.sv
package ksmh_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 31;
    localparam int MEM_W    = KEY_W + VAL_W;
    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 10;
    localparam int STS_W    = 3;

    localparam logic [CNT_W-1:0] K_RESET = CNT_W'(CAPACITY);

    typedef enum logic [MODE_W-1:0] {
        MODE_OFFER = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef enum logic [STS_W-1:0] {
        STS_INSERTED = 3'd0,
        STS_REPLACED = 3'd1,
        STS_DISCARD  = 3'd2,
        STS_READ_OK  = 3'd3,
        STS_RANGE    = 3'd4,
        STS_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_DN,
        ST_FIN,
        ST_RD,
        ST_DONE
    } t_state;

endpackage

### sv/ksmh_in_if.sv
interface ksmh_in_if
    import ksmh_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic signed [KEY_W-1:0]   key;
    logic [VAL_W-1:0]          val;
    logic [INDEX_W-1:0]        index;

    modport source (output valid, mode, key, val, index, input ready);
    modport sink   (input valid, mode, key, val, index, output ready);
endinterface

### sv/ksmh_out_if.sv
interface ksmh_out_if
    import ksmh_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STS_W-1:0]          status;
    logic [CNT_W-1:0]          count;
    logic signed [KEY_W-1:0]   out_key;
    logic [VAL_W-1:0]          out_val;

    modport source (output valid, status, count, out_key, out_val, input ready);
    modport sink   (input valid, status, count, out_key, out_val, output ready);
endinterface

### sv/ksmh_ram.sv
module ksmh_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 63
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### sv/k_smallest_max_heap.sv
// k_smallest_max_heap: keeps the k smallest (key, val) pairs in a max-heap held in
// a 1024-entry ram with two read ports and one write port.
// i_in carries one beat per item: mode selects offer, read at index, or clear; other modes give a range status.
// o_out carries one result beat per item: status, count and a key/val pair
// (the root after an offer, the entry after a read, zero otherwise).
// i_cfg_we / i_cfg_wdata write k_in_use; write it only while the block is idle.
// one item is handled at a time. an offer sifts its entry up (ST_UP, insert) or down
// (ST_DN, replace), one ram read and one compare and write-back per level, passes
// ST_FIN when it reaches the root or a slot with no child, and ends in ST_DONE; it
// skips the sift when it writes the root directly (empty heap, or replace with a single
// entry held). reads go via ST_RD; clears, discards, out-of-range reads go to ST_DONE.
// ready is high only in the idle state; the next beat can be taken in the cycle
// after the result enters the output register, while that result still waits.
// if o_out.ready stays low, a finished result waits in the done state until the
// output register frees up.
// reset (synchronous, active low) empties the heap and sets k_in_use to 1024;
// the ram itself is not cleared, entries past the count are never used.
`include "assert_macros.svh"

module k_smallest_max_heap
    import ksmh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ksmh_in_if.sink           i_in,
    ksmh_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata
);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [CNT_W-1:0]         r_k;
    logic [ADDR_W-1:0]        r_pos, n_pos;
    logic signed [KEY_W-1:0]  r_hk, n_hk;
    logic [VAL_W-1:0]         r_hv, n_hv;
    t_status                  r_status, n_status;
    logic signed [KEY_W-1:0]  r_root_key;
    logic [VAL_W-1:0]         r_root_val;
    logic                     r_ov;
    t_status                  r_o_status;
    logic [CNT_W-1:0]         r_o_count;
    logic signed [KEY_W-1:0]  r_o_key;
    logic [VAL_W-1:0]         r_o_val;

    logic                     w_we;
    logic [ADDR_W-1:0]        w_waddr, w_raddr_a, w_raddr_b;
    logic [MEM_W-1:0]         w_wdata, w_rd_a, w_rd_b;
    logic signed [KEY_W-1:0]  w_ak, w_bk, w_best_k;
    logic [VAL_W-1:0]         w_av;

    logic [CNT_W-1:0]         w_cap;
    logic                     w_accept, w_ins, w_rep, w_rd_ok, w_load;
    logic [ADDR_W-1:0]        w_up, w_up_up;
    logic                     w_up_gt;
    logic [CNT_W:0]           w_lc, w_rc, w_nlc, w_ncnt;
    logic                     w_l_gt, w_r_gt, w_move, w_nlc_ok;
    logic [ADDR_W-1:0]        w_big;
    logic [MEM_W-1:0]         w_big_data;

    ksmh_ram #(.DEPTH(CAPACITY), .WIDTH(MEM_W)) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    assign w_ak = signed'(w_rd_a[MEM_W-1:VAL_W]);
    assign w_av = w_rd_a[VAL_W-1:0];
    assign w_bk = signed'(w_rd_b[MEM_W-1:VAL_W]);

    always_comb begin
        if (r_k == '0) begin
            w_cap = CNT_W'(1);
        end else if (r_k > CNT_W'(CAPACITY)) begin
            w_cap = CNT_W'(CAPACITY);
        end else begin
            w_cap = r_k;
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_ins      = (r_cnt < w_cap);
    assign w_rep      = (r_cnt != '0) && (r_root_key > i_in.key);
    assign w_rd_ok    = ({1'b0, i_in.index} < r_cnt);
    assign w_load     = (r_state == ST_DONE) && (!r_ov || o_out.ready);

    // sift-up: parent of the hole and the parent after that
    assign w_up    = (r_pos - ADDR_W'(1)) >> 1;
    assign w_up_up = (w_up - ADDR_W'(1)) >> 1;
    assign w_up_gt = (r_hk > w_ak);

    // sift-down: children of the hole, left wins a tie
    assign w_ncnt     = {1'b0, r_cnt};
    assign w_lc       = {1'b0, r_pos, 1'b1};
    assign w_rc       = w_lc + (CNT_W+1)'(1);
    assign w_l_gt     = (w_lc < w_ncnt) && (w_ak > r_hk);
    assign w_best_k   = w_l_gt ? w_ak : r_hk;
    assign w_r_gt     = (w_rc < w_ncnt) && (w_bk > w_best_k);
    assign w_move     = w_l_gt || w_r_gt;
    assign w_big      = w_r_gt ? w_rc[ADDR_W-1:0] : w_lc[ADDR_W-1:0];
    assign w_big_data = w_r_gt ? w_rd_b : w_rd_a;
    assign w_nlc      = {1'b0, w_big, 1'b1};
    assign w_nlc_ok   = (w_nlc < w_ncnt);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (t_mode'(i_in.mode))
                        MODE_OFFER: begin
                            if (w_ins) begin
                                n_state = (r_cnt == '0) ? ST_DONE : ST_UP;
                            end else if (w_rep) begin
                                n_state = (r_cnt == CNT_W'(1)) ? ST_DONE : ST_DN;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        MODE_READ:  n_state = w_rd_ok ? ST_RD : ST_DONE;
                        MODE_CLEAR: n_state = ST_DONE;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_UP: begin
                if (!w_up_gt) begin
                    n_state = ST_DONE;
                end else if (w_up == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_DN: begin
                if (!w_move) begin
                    n_state = ST_DONE;
                end else if (!w_nlc_ok) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:  n_state = ST_DONE;
            ST_RD:   n_state = ST_DONE;
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_hk      = r_hk;
        n_hv      = r_hv;
        n_status  = r_status;
        w_we      = 1'b0;
        w_waddr   = r_pos;
        w_wdata   = {r_hk, r_hv};
        w_raddr_a = w_up;
        w_raddr_b = w_rc[ADDR_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_hk = i_in.key;
                    n_hv = i_in.val;
                    case (t_mode'(i_in.mode))
                        MODE_OFFER: begin
                            if (w_ins) begin
                                n_status  = STS_INSERTED;
                                n_cnt     = r_cnt + CNT_W'(1);
                                n_pos     = r_cnt[ADDR_W-1:0];
                                w_raddr_a = ADDR_W'((r_cnt - CNT_W'(1)) >> 1);
                                if (r_cnt == '0) begin
                                    w_we    = 1'b1;
                                    w_waddr = '0;
                                    w_wdata = {i_in.key, i_in.val};
                                end
                            end else if (w_rep) begin
                                n_status  = STS_REPLACED;
                                n_pos     = '0;
                                w_raddr_a = ADDR_W'(1);
                                w_raddr_b = ADDR_W'(2);
                                if (r_cnt == CNT_W'(1)) begin
                                    w_we    = 1'b1;
                                    w_waddr = '0;
                                    w_wdata = {i_in.key, i_in.val};
                                end
                            end else begin
                                n_status = STS_DISCARD;
                            end
                        end
                        MODE_READ: begin
                            n_status  = w_rd_ok ? STS_READ_OK : STS_RANGE;
                            w_raddr_a = i_in.index[ADDR_W-1:0];
                        end
                        MODE_CLEAR: begin
                            n_status = STS_CLEARED;
                            n_cnt    = '0;
                        end
                        default: n_status = STS_RANGE;
                    endcase
                end
            end
            ST_UP: begin
                w_we      = 1'b1;
                w_raddr_a = w_up_up;
                if (w_up_gt) begin
                    w_wdata = w_rd_a;
                    n_pos   = w_up;
                end
            end
            ST_DN: begin
                w_we      = 1'b1;
                w_raddr_a = w_nlc[ADDR_W-1:0];
                w_raddr_b = ADDR_W'(w_nlc + (CNT_W+1)'(1));
                if (w_move) begin
                    w_wdata = w_big_data;
                    n_pos   = w_big;
                end
            end
            ST_FIN: begin
                w_we = 1'b1;
            end
            ST_RD: begin
                n_hk = w_ak;
                n_hv = w_av;
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_k     <= K_RESET;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_k <= i_cfg_wdata;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload, root copy follows every write to the top of the heap
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_hk     <= n_hk;
        r_hv     <= n_hv;
        r_status <= n_status;
        if (w_we && (w_waddr == '0)) begin
            r_root_key <= signed'(w_wdata[MEM_W-1:VAL_W]);
            r_root_val <= w_wdata[VAL_W-1:0];
        end
        if (w_load) begin
            r_o_status <= r_status;
            r_o_count  <= r_cnt;
            r_o_key    <= '0;
            r_o_val    <= '0;
            if (r_status == STS_READ_OK) begin
                r_o_key <= r_hk;
                r_o_val <= r_hv;
            end else if ((r_status == STS_INSERTED || r_status == STS_REPLACED ||
                          r_status == STS_DISCARD) && (r_cnt != '0)) begin
                r_o_key <= r_root_key;
                r_o_val <= r_root_val;
            end
        end
    end

    assign o_out.valid   = r_ov;
    assign o_out.status  = r_o_status;
    assign o_out.count   = r_o_count;
    assign o_out.out_key = r_o_key;
    assign o_out.out_val = r_o_val;

    `ASSERT_ALWAYS(a_cnt_bound, r_cnt <= CNT_W'(CAPACITY), "entry count above capacity")
    `ASSERT_IMPLY(a_wr_in_heap, w_we, {1'b0, w_waddr} < n_cnt, "write past the entry count")
    `ASSERT_IMPLY(a_up_not_root, r_state == ST_UP, r_pos != '0, "sift-up climbing from root")
    `ASSERT_IMPLY(a_dn_child, r_state == ST_DN, w_lc < w_ncnt, "sift-down without a child")
    `ASSERT_IMPLY(a_done_cnt, r_state == ST_DONE && r_status == STS_INSERTED, r_cnt != '0,
                  "insert left the heap empty")

endmodule

### tb/k_smallest_max_heap_tb.sv
`timescale 1ns / 1ps

module k_smallest_max_heap_tb;
    import ksmh_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_LO = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_HI = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_HI = '1;

    typedef struct {
        logic [MODE_W-1:0]       mode;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        val;
        logic [INDEX_W-1:0]      index;
    } t_heap_item;

    typedef struct {
        logic [STS_W-1:0]        status;
        logic [CNT_W-1:0]        count;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        val;
    } t_heap_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    ksmh_in_if  in_if ();
    ksmh_out_if out_if ();

    k_smallest_max_heap uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predicted heap contents and k register
    logic signed [KEY_W-1:0] held_key [CAPACITY];
    logic [VAL_W-1:0]        held_val [CAPACITY];
    int                      held_count = 0;
    logic [CNT_W-1:0]        heap_k = K_RESET;

    t_heap_item   heap_ops [$];
    t_heap_result due_results [$];

    int fails = 0;
    int sts_tally [6];
    int peak_count = 0;
    int k_writes = 0;
    int send_gap = 0;
    int recv_stall = 0;
    bit sender_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    int plan_count = 0;
    int plan_k = CAPACITY;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_heap_result heap_apply(t_heap_item it);
        t_heap_result res;
        int cap;
        int pos;
        int up;
        int big;
        int lc;
        int rc;
        logic signed [KEY_W-1:0] hk;
        logic [VAL_W-1:0] hv;
        cap = (heap_k == 0) ? 1 : (heap_k > CAPACITY) ? CAPACITY : int'(heap_k);
        res.status = STS_RANGE;
        res.key = '0;
        res.val = '0;
        case (it.mode)
            MODE_OFFER: begin
                if (held_count < cap) begin
                    pos = held_count;
                    hk = it.key;
                    hv = it.val;
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (!(hk > held_key[up])) break;
                        held_key[pos] = held_key[up];
                        held_val[pos] = held_val[up];
                        pos = up;
                    end
                    held_key[pos] = hk;
                    held_val[pos] = hv;
                    held_count++;
                    res.status = STS_INSERTED;
                end else if (held_key[0] > it.key) begin
                    held_key[0] = it.key;
                    held_val[0] = it.val;
                    pos = 0;
                    while (1) begin
                        big = pos;
                        lc = 2 * pos + 1;
                        rc = 2 * pos + 2;
                        if (lc < held_count && held_key[lc] > held_key[big]) big = lc;
                        if (rc < held_count && held_key[rc] > held_key[big]) big = rc;
                        if (big == pos) break;
                        hk = held_key[pos];
                        hv = held_val[pos];
                        held_key[pos] = held_key[big];
                        held_val[pos] = held_val[big];
                        held_key[big] = hk;
                        held_val[big] = hv;
                        pos = big;
                    end
                    res.status = STS_REPLACED;
                end else begin
                    res.status = STS_DISCARD;
                end
                if (held_count > 0) begin
                    res.key = held_key[0];
                    res.val = held_val[0];
                end
            end
            MODE_READ: begin
                if (it.index < held_count) begin
                    res.status = STS_READ_OK;
                    res.key = held_key[it.index];
                    res.val = held_val[it.index];
                end
            end
            MODE_CLEAR: begin
                held_count = 0;
                res.status = STS_CLEARED;
            end
            default: ;
        endcase
        res.count = CNT_W'(held_count);
        return res;
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return int'($urandom_range(0, 16)) - 8;
        if (r < 30) begin
            case ($urandom_range(0, 3))
                0: return KEY_LO;
                1: return KEY_HI;
                2: return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [VAL_W-1:0] pick_val();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return VAL_HI;
        return VAL_W'($urandom);
    endfunction

    task automatic queue_item(logic [MODE_W-1:0] mode, logic signed [KEY_W-1:0] key,
                              logic [VAL_W-1:0] val, logic [INDEX_W-1:0] index);
        t_heap_item it;
        it.mode = mode;
        it.key = key;
        it.val = val;
        it.index = index;
        heap_ops.push_back(it);
        if (mode == MODE_OFFER && plan_count < plan_k) plan_count++;
        if (mode == MODE_CLEAR) plan_count = 0;
    endtask

    task automatic queue_random(int clear_pct);
        int r;
        logic [INDEX_W-1:0] idx;
        r = $urandom_range(0, 99);
        idx = INDEX_W'($urandom_range(0, 1023));
        if (r < 68) begin
            queue_item(MODE_OFFER, pick_key(), pick_val(), idx);
        end else if (r < 80) begin
            if (plan_count > 0) idx = INDEX_W'($urandom_range(0, plan_count - 1));
            queue_item(MODE_READ, pick_key(), pick_val(), idx);
        end else if (r < 88) begin
            queue_item(MODE_READ, pick_key(), pick_val(), idx);
        end else if (r < 88 + clear_pct) begin
            queue_item(MODE_CLEAR, pick_key(), pick_val(), idx);
        end else if (r == 99) begin
            queue_item(MODE_NONE, pick_key(), pick_val(), idx);
        end else begin
            queue_item(MODE_OFFER, pick_key(), pick_val(), idx);
        end
    endtask

    // wait until every item is sent and every result is back
    task automatic settle();
        @(negedge i_clk);
        while (heap_ops.size() != 0 || in_if.valid || due_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(int k, int n, int clear_pct);
        settle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= CNT_W'(k);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        k_writes++;
        plan_k = (k == 0) ? 1 : (k > CAPACITY) ? CAPACITY : k;
        @(negedge i_clk);
        sender_idle_on = ($urandom_range(0, 3) != 0);
        recv_idle_on = ($urandom_range(0, 3) != 0);
        repeat (n) queue_random(clear_pct);
    endtask

    // sender
    always @(posedge i_clk) begin
        t_heap_item it;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap = 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (send_gap > 0) begin
                in_if.valid <= 1'b0;
                send_gap--;
            end else if (heap_ops.size() > 0) begin
                it = heap_ops.pop_front();
                in_if.mode <= it.mode;
                in_if.key <= it.key;
                in_if.val <= it.val;
                in_if.index <= it.index;
                in_if.valid <= 1'b1;
                if (sender_idle_on) send_gap = pause_len();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_stall = 0;
        end else if (recv_stall > 0) begin
            out_if.ready <= 1'b0;
            recv_stall--;
        end else begin
            out_if.ready <= 1'b1;
            if (recv_idle_on && $urandom_range(0, 2) == 0) recv_stall = pause_len();
        end
    end

    // predict on each input beat, check each output beat
    always @(posedge i_clk) begin
        t_heap_item it;
        t_heap_result want;
        if (i_rst_n) begin
            if (i_cfg_we) heap_k = i_cfg_wdata;
            if (in_if.valid && in_if.ready) begin
                it.mode = in_if.mode;
                it.key = in_if.key;
                it.val = in_if.val;
                it.index = in_if.index;
                want = heap_apply(it);
                sts_tally[want.status]++;
                if (int'(want.count) > peak_count) peak_count = int'(want.count);
                due_results.push_back(want);
            end
            if (out_if.valid && out_if.ready) begin
                if (due_results.size() == 0) begin
                    $error("result beat with nothing expected: status %0d count %0d",
                           out_if.status, out_if.count);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    if (out_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_if.status);
                        fails++;
                    end
                    if (out_if.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, out_if.count);
                        fails++;
                    end
                    if (out_if.out_key !== want.key) begin
                        $error("out_key: expected %0d, got %0d", want.key, out_if.out_key);
                        fails++;
                    end
                    if (out_if.out_val !== want.val) begin
                        $error("out_val: expected %0d, got %0d", want.val, out_if.out_val);
                        fails++;
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("k_smallest_max_heap_tb NOT OK");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.mode = MODE_OFFER;
        in_if.key = '0;
        in_if.val = '0;
        in_if.index = '0;
        out_if.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset value of k, empty heap, extremes, ties, bad mode
        queue_item(MODE_READ, 0, 0, 0);
        queue_item(MODE_OFFER, 0, 0, 0);
        queue_item(MODE_OFFER, KEY_HI, VAL_HI, 0);
        queue_item(MODE_OFFER, KEY_LO, 1, 0);
        queue_item(MODE_OFFER, -1, 2, 0);
        queue_item(MODE_OFFER, KEY_HI, 3, 0);
        queue_item(MODE_OFFER, 5, 4, 0);
        for (int i = 0; i < 6; i++) queue_item(MODE_READ, 0, 0, INDEX_W'(i));
        queue_item(MODE_READ, KEY_HI, VAL_HI, 6);
        queue_item(MODE_READ, 0, 0, 10'h3ff);
        queue_item(MODE_NONE, KEY_LO, VAL_HI, 0);
        queue_item(MODE_CLEAR, 0, 0, 0);
        queue_item(MODE_READ, 0, 0, 0);
        queue_item(MODE_NONE, 0, 0, 10'h3ff);
        queue_item(MODE_OFFER, 7, 9, 0);

        // k of zero acts as one: replace, tie discard, larger discard
        run_phase(0, 0, 3);
        queue_item(MODE_OFFER, 5, 10, 0);
        queue_item(MODE_OFFER, 3, 11, 0);
        queue_item(MODE_OFFER, 3, 12, 0);
        queue_item(MODE_OFFER, 9, 13, 0);
        queue_item(MODE_OFFER, KEY_LO, 14, 0);
        queue_item(MODE_READ, 0, 0, 0);
        queue_item(MODE_READ, 0, 0, 1);
        repeat (60) queue_random(3);

        run_phase(1, 50, 3);
        run_phase(2, 80, 3);
        run_phase(7, 150, 3);
        run_phase(16, 150, 2);
        // k lowered below the count held
        run_phase(3, 60, 0);
        run_phase(2047, 250, 0);
        run_phase(1024, 80, 1);
        run_phase(5, 60, 3);

        settle();
        repeat (20) @(posedge i_clk);
        $display("ran %0d inserts, %0d replaces, %0d discards, %0d clears, peak count %0d",
                 sts_tally[STS_INSERTED], sts_tally[STS_REPLACED], sts_tally[STS_DISCARD],
                 sts_tally[STS_CLEARED], peak_count);
        $display("reads: %0d in range, %0d out of range or bad mode; %0d k settings",
                 sts_tally[STS_READ_OK], sts_tally[STS_RANGE], k_writes);
        if (fails == 0) begin
            $display("k_smallest_max_heap_tb OK");
        end else begin
            $display("k_smallest_max_heap_tb NOT OK");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/ksmh_pkg.sv
sv/ksmh_in_if.sv
sv/ksmh_out_if.sv
sv/ksmh_ram.sv
sv/k_smallest_max_heap.sv
tb/k_smallest_max_heap_tb.sv
